/* hw/rtl/cau_pkg.sv */
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

endpackage

/* hw/rtl/cau_prep.sv */
// operand stage: products, sums, divisor and magnitudes, registered
module cau_prep #(
  parameter int DW = 16,
  parameter int NW = 2 * DW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  cau_pkg::op_t         op_i,
  input  logic signed [DW-1:0] ar,
  input  logic signed [DW-1:0] ai,
  input  logic signed [DW-1:0] br,
  input  logic signed [DW-1:0] bi,
  output logic                 vld_o,
  output cau_pkg::op_t         op_o,
  output logic [NW-1:0]        mr_o,
  output logic [NW-1:0]        mi_o,
  output logic                 nr_o,
  output logic                 ni_o,
  output logic [NW-1:0]        d_o
);
  import cau_pkg::*;

  logic signed [2*DW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [NW-1:0]   sr, si;
  logic [NW-1:0]          dsum;
  logic                   vld_r;
  op_t                    op_r;
  logic [NW-1:0]          mr_r, mi_r, d_r;
  logic                   nr_r, ni_r;

  always_comb begin
    p_rr = ar * br;
    p_ii = ai * bi;
    p_ri = ar * bi;
    p_ir = ai * br;
    p_bb = br * br;
    p_cc = bi * bi;
    dsum = NW'($unsigned(p_bb)) + NW'($unsigned(p_cc));
    case (op_i)
      OP_ADD: begin
        sr = NW'(ar) + NW'(br);
        si = NW'(ai) + NW'(bi);
      end
      OP_SUB: begin
        sr = NW'(ar) - NW'(br);
        si = NW'(ai) - NW'(bi);
      end
      OP_MUL: begin
        sr = NW'(p_rr) - NW'(p_ii);
        si = NW'(p_ri) + NW'(p_ir);
      end
      default: begin
        sr = NW'(p_rr) + NW'(p_ii);
        si = NW'(p_ir) - NW'(p_ri);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      op_r <= op_i;
      nr_r <= sr[NW-1];
      ni_r <= si[NW-1];
      mr_r <= sr[NW-1] ? -sr : sr;
      mi_r <= si[NW-1] ? -si : si;
      d_r  <= dsum;
    end
  end

  assign vld_o = vld_r;
  assign op_o  = op_r;
  assign mr_o  = mr_r;
  assign mi_o  = mi_r;
  assign nr_o  = nr_r;
  assign ni_o  = ni_r;
  assign d_o   = d_r;

endmodule

/* hw/rtl/cau_cell.sv */
// one restoring division step for both parts, handed to the next cell
module cau_cell #(
  parameter int NW = 34,
  parameter int QW = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  cau_pkg::op_t  op_i,
  input  logic [NW-1:0] d_i,
  input  logic [NW:0]   rr_i,
  input  logic [NW:0]   ri_i,
  input  logic [QW-1:0] qr_i,
  input  logic [QW-1:0] qi_i,
  input  logic [NW-1:0] nr_bits_i,
  input  logic [NW-1:0] ni_bits_i,
  input  logic [1:0]    sg_i,
  input  logic [NW-1:0] mr_i,
  input  logic [NW-1:0] mi_i,
  output logic          vld_o,
  output cau_pkg::op_t  op_o,
  output logic [NW-1:0] d_o,
  output logic [NW:0]   rr_o,
  output logic [NW:0]   ri_o,
  output logic [QW-1:0] qr_o,
  output logic [QW-1:0] qi_o,
  output logic [NW-1:0] nr_bits_o,
  output logic [NW-1:0] ni_bits_o,
  output logic [1:0]    sg_o,
  output logic [NW-1:0] mr_o,
  output logic [NW-1:0] mi_o
);
  import cau_pkg::*;

  logic [NW+1:0] tr, ti;
  logic          gr, gi;
  logic          vld_r;
  op_t           op_r;
  logic [NW-1:0] d_r, nrb_r, nib_r, mr_r, mi_r;
  logic [NW:0]   rr_r, ri_r;
  logic [QW-1:0] qr_r, qi_r;
  logic [1:0]    sg_r;

  always_comb begin
    tr = {rr_i, nr_bits_i[NW-1]};
    ti = {ri_i, ni_bits_i[NW-1]};
    gr = tr >= {2'b00, d_i};
    gi = ti >= {2'b00, d_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      op_r  <= op_i;
      d_r   <= d_i;
      rr_r  <= (NW+1)'(gr ? tr - {2'b00, d_i} : tr);
      ri_r  <= (NW+1)'(gi ? ti - {2'b00, d_i} : ti);
      qr_r  <= {qr_i[QW-2:0], gr};
      qi_r  <= {qi_i[QW-2:0], gi};
      nrb_r <= {nr_bits_i[NW-2:0], 1'b0};
      nib_r <= {ni_bits_i[NW-2:0], 1'b0};
      sg_r  <= sg_i;
      mr_r  <= mr_i;
      mi_r  <= mi_i;
    end
  end

  assign vld_o = vld_r;
  assign op_o  = op_r;
  assign d_o   = d_r;
  assign rr_o  = rr_r;
  assign ri_o  = ri_r;
  assign qr_o  = qr_r;
  assign qi_o  = qi_r;
  assign nr_bits_o = nrb_r;
  assign ni_bits_o = nib_r;
  assign sg_o  = sg_r;
  assign mr_o  = mr_r;
  assign mi_o  = mi_r;

endmodule

/* hw/rtl/cau_fin.sv */
// rounding, saturation and flags, registered output
module cau_fin #(
  parameter int DW = 16,
  parameter int FB = 8,
  parameter int NW = 34,
  parameter int QW = 36
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  cau_pkg::op_t         op_i,
  input  logic [NW-1:0]        d_i,
  input  logic [NW:0]          rr_i,
  input  logic [NW:0]          ri_i,
  input  logic [QW-1:0]        qr_i,
  input  logic [QW-1:0]        qi_i,
  input  logic [1:0]           sg_i,
  input  logic [NW-1:0]        mr_i,
  input  logic [NW-1:0]        mi_i,
  output logic                 vld_o,
  output logic signed [DW-1:0] re_o,
  output logic signed [DW-1:0] im_o,
  output logic                 dz_o,
  output logic                 sat_o
);
  import cau_pkg::*;

  localparam logic [QW:0] LPOS = (QW+1)'((64'd1 << (DW-1)) - 1);
  localparam logic [QW:0] LNEG = (QW+1)'(64'd1 << (DW-1));
  localparam logic [NW:0] HALF = (FB > 0) ? (NW+1)'(64'd1 << (FB > 0 ? FB-1 : 0)) : '0;

  logic [QW:0]        mag_r, mag_i;
  logic [DW-1:0]      o_r, o_i;
  logic               c_r, c_i, dz;
  logic               vld_r, dz_r, sat_r;
  logic [DW-1:0]      re_r, im_r;

  function automatic logic [DW:0] sat_f(input logic neg, input logic [QW:0] m);
    logic [DW-1:0] v;
    logic          c;
    c = 1'b0;
    if (neg) begin
      if (m > LNEG) begin
        c = 1'b1;
        v = DW'(LNEG);
      end else begin
        v = DW'(-m);
      end
    end else begin
      if (m > LPOS) begin
        c = 1'b1;
        v = DW'(LPOS);
      end else begin
        v = DW'(m);
      end
    end
    return {c, v};
  endfunction

  always_comb begin
    dz = 1'b0;
    if (op_i == OP_DIV) begin
      mag_r = (QW+1)'(qr_i) + (QW+1)'({rr_i, 1'b0} >= {2'b00, d_i});
      mag_i = (QW+1)'(qi_i) + (QW+1)'({ri_i, 1'b0} >= {2'b00, d_i});
      dz    = (d_i == '0);
    end else if (op_i == OP_MUL) begin
      mag_r = (QW+1)'(((NW+1)'(mr_i) + HALF) >> FB);
      mag_i = (QW+1)'(((NW+1)'(mi_i) + HALF) >> FB);
    end else begin
      mag_r = (QW+1)'(mr_i);
      mag_i = (QW+1)'(mi_i);
    end
    {c_r, o_r} = sat_f(sg_i[0], mag_r);
    {c_i, o_i} = sat_f(sg_i[1], mag_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
    if (en) begin
      re_r  <= dz ? '0 : o_r;
      im_r  <= dz ? '0 : o_i;
      dz_r  <= dz;
      sat_r <= dz ? 1'b0 : (c_r | c_i);
    end
  end

  assign vld_o = vld_r;
  assign re_o  = re_r;
  assign im_o  = im_r;
  assign dz_o  = dz_r;
  assign sat_o = sat_r;

endmodule

/* hw/rtl/complex_arithmetic_unit.sv */
// complex arithmetic unit: add, subtract, multiply, divide on signed fixed point
// input channel in_*: one beat carries an op code (in_tuser) and two complex
//   operands a and b (in_tdata); output channel out_*: one beat per input beat
//   with the result parts (out_tdata) and the flags div_zero, saturated (out_tuser)
// structure: NW = 2*DATA_WIDTH+2 (34 at the default width); one operand stage,
//   a chain of NW+FRAC_BITS division cells each resolving one quotient bit per
//   cycle when not stalled, and a rounding/saturation stage that is the output
// throughput: one beat per cycle while the output is not stalled; every op travels
//   the whole chain so results leave in order
// stall: the whole chain advances only when the output register is empty or
//   taken, so in_tready follows out_tready (or a bubble in the output register)
// reset: rst_n synchronous, clears all valid bits; the data registers are not reset
// divide by zero gives a zero result and sets div_zero
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [4*DATA_WIDTH-1:0] in_tdata,  // a_re, a_im, b_re, b_im
  input  logic [1:0]              in_tuser,  // kind
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [2*DATA_WIDTH-1:0] out_tdata, // res_re, res_im
  output logic [1:0]              out_tuser  // div_zero, saturated
);
  import cau_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int NW = 2 * DW + 2;       // numerator and divisor width
  localparam int QW = NW + FRAC_BITS;   // quotient width
  localparam int NC = QW;               // cells: one quotient bit each

  logic en;

  // chain buses, index 0 fed by the operand stage
  logic          c_vld [NC+1];
  op_t           c_op  [NC+1];
  logic [NW-1:0] c_d   [NC+1];
  logic [NW:0]   c_rr  [NC+1];
  logic [NW:0]   c_ri  [NC+1];
  logic [QW-1:0] c_qr  [NC+1];
  logic [QW-1:0] c_qi  [NC+1];
  logic [NW-1:0] c_nr  [NC+1];
  logic [NW-1:0] c_ni  [NC+1];
  logic [1:0]    c_sg  [NC+1];
  logic [NW-1:0] c_mr  [NC+1];
  logic [NW-1:0] c_mi  [NC+1];

  logic          p_nr, p_ni;
  logic signed [DW-1:0] re, im;
  logic          dz, sat;

  // output register is the last stage; advance when it is free or drained
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  cau_prep #(.DW(DW), .NW(NW)) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (in_tvalid),
    .op_i  (op_t'(in_tuser)),
    .ar    (in_tdata[DW-1:0]),
    .ai    (in_tdata[2*DW-1:DW]),
    .br    (in_tdata[3*DW-1:2*DW]),
    .bi    (in_tdata[4*DW-1:3*DW]),
    .vld_o (c_vld[0]),
    .op_o  (c_op[0]),
    .mr_o  (c_mr[0]),
    .mi_o  (c_mi[0]),
    .nr_o  (p_nr),
    .ni_o  (p_ni),
    .d_o   (c_d[0])
  );

  // numerators enter the chain as shift-in bits, remainders start at zero
  assign c_rr[0] = '0;
  assign c_ri[0] = '0;
  assign c_qr[0] = '0;
  assign c_qi[0] = '0;
  assign c_nr[0] = c_mr[0];
  assign c_ni[0] = c_mi[0];
  assign c_sg[0] = {p_ni, p_nr};

  for (genvar k = 0; k < NC; k++) begin : g_cell
    cau_cell #(.NW(NW), .QW(QW)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .vld_i     (c_vld[k]),
      .op_i      (c_op[k]),
      .d_i       (c_d[k]),
      .rr_i      (c_rr[k]),
      .ri_i      (c_ri[k]),
      .qr_i      (c_qr[k]),
      .qi_i      (c_qi[k]),
      .nr_bits_i (c_nr[k]),
      .ni_bits_i (c_ni[k]),
      .sg_i      (c_sg[k]),
      .mr_i      (c_mr[k]),
      .mi_i      (c_mi[k]),
      .vld_o     (c_vld[k+1]),
      .op_o      (c_op[k+1]),
      .d_o       (c_d[k+1]),
      .rr_o      (c_rr[k+1]),
      .ri_o      (c_ri[k+1]),
      .qr_o      (c_qr[k+1]),
      .qi_o      (c_qi[k+1]),
      .nr_bits_o (c_nr[k+1]),
      .ni_bits_o (c_ni[k+1]),
      .sg_o      (c_sg[k+1]),
      .mr_o      (c_mr[k+1]),
      .mi_o      (c_mi[k+1])
    );
  end

  cau_fin #(.DW(DW), .FB(FRAC_BITS), .NW(NW), .QW(QW)) u_fin (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (c_vld[NC]),
    .op_i  (c_op[NC]),
    .d_i   (c_d[NC]),
    .rr_i  (c_rr[NC]),
    .ri_i  (c_ri[NC]),
    .qr_i  (c_qr[NC]),
    .qi_i  (c_qi[NC]),
    .sg_i  (c_sg[NC]),
    .mr_i  (c_mr[NC]),
    .mi_i  (c_mi[NC]),
    .vld_o (out_tvalid),
    .re_o  (re),
    .im_o  (im),
    .dz_o  (dz),
    .sat_o (sat)
  );

  assign out_tdata = {im, re};
  assign out_tuser = {sat, dz};

endmodule

/* hw/rtl/cau_checker.sv */
module cau_checker #(
  parameter int DW = 16
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [2*DW-1:0] out_tdata,
  input logic [1:0]    out_tuser
);
  // divide by zero always comes with a zero result
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("div_zero with nonzero result");

  // divide by zero never reports saturation
  a_dz_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1])
    else $error("div_zero with saturated");

  // stalled output holds its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");

  // input side is open whenever the output is empty
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
endmodule

bind complex_arithmetic_unit cau_checker #(.DW(DATA_WIDTH)) u_cau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
